FILE: rtl/lth_pkg.sv
// lth_pkg: shared types and constants for the letter trigram histogram.
// Holds the Cyrillic/Kazakh letter tables and the lookup function.
// No dependencies.
package lth_pkg;

    localparam int LETTER_COUNT = 42;
    localparam int CP_W         = 21;
    localparam int QIDX_W       = 17;
    localparam int OUT_CNT_W    = 32;
    localparam int OUT_DEPTH    = 8;   // result queue entries
    localparam int OUT_PTR_W    = 3;
    localparam int OUT_LVL_W    = 4;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INCR,
        OP_QUERY
    } t_op;

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } t_letter;

    // Lower-case forms, index = folded letter code
    localparam logic [CP_W-1:0] LOWER_CP [LETTER_COUNT] = '{
        21'h430, 21'h4D9, 21'h431, 21'h432, 21'h433, 21'h493, 21'h434, 21'h435,
        21'h451, 21'h436, 21'h437, 21'h438, 21'h439, 21'h43A, 21'h49B, 21'h43B,
        21'h43C, 21'h43D, 21'h4A3, 21'h43E, 21'h4E9, 21'h43F, 21'h440, 21'h441,
        21'h442, 21'h443, 21'h4B1, 21'h4AF, 21'h444, 21'h445, 21'h4BB, 21'h446,
        21'h447, 21'h448, 21'h449, 21'h44A, 21'h44B, 21'h456, 21'h44C, 21'h44D,
        21'h44E, 21'h44F
    };

    // Upper-case forms, same order
    localparam logic [CP_W-1:0] UPPER_CP [LETTER_COUNT] = '{
        21'h410, 21'h4D8, 21'h411, 21'h412, 21'h413, 21'h492, 21'h414, 21'h415,
        21'h401, 21'h416, 21'h417, 21'h418, 21'h419, 21'h41A, 21'h49A, 21'h41B,
        21'h41C, 21'h41D, 21'h4A2, 21'h41E, 21'h4E8, 21'h41F, 21'h420, 21'h421,
        21'h422, 21'h423, 21'h4B0, 21'h4AE, 21'h424, 21'h425, 21'h4BA, 21'h426,
        21'h427, 21'h428, 21'h429, 21'h42A, 21'h42B, 21'h406, 21'h42C, 21'h42D,
        21'h42E, 21'h42F
    };

    // Parallel compare against all 84 code points, upper case folded.
    function automatic t_letter letter_lookup(input logic [CP_W-1:0] cp);
        t_letter res;
        res.hit  = 1'b0;
        res.code = '0;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            if (LOWER_CP[i] == cp || UPPER_CP[i] == cp) begin
                res.hit  = 1'b1;
                res.code = 6'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/letter_trigram_histogram.sv
// letter_trigram_histogram: counts three-letter runs in a code point stream
// and answers count queries. Depends on lth_pkg.
//
// Channel   Dir  Signals                        Contents
// --------  ---  -----------------------------  ---------------------------------
// input     in   i_s_tvalid/o_s_tready          tuser: req_type
//                i_s_tdata[39:0], i_s_tuser     tdata: code_point, query_index
// result    out  o_m_tvalid/i_m_tready          tdata: trigram_index,
//                o_m_tdata[55:0]                       trigram_count
//
// One item per cycle while o_s_tready is high. An item passes input register,
// letter decode and history update, counter RAM read, then increment/write-back;
// a query result passes the stage 1, 2 and 3 registers into the output queue.
// The counter RAM has one write and one read port; a read that meets the
// write of the item just ahead takes the written value from a bypass register.
// After reset a clearing sweep writes zero to every counter, one per cycle:
// ALPHABET_SIZE^3 counters (74088 at the default), o_s_tready low meanwhile.
// Stalls: queries reserve a slot in an 8-entry result queue at transfer time, so
// the pipeline never stops; in ST_RUN o_s_tready drops only when slots are full.
module letter_trigram_histogram #(
    parameter int ALPHABET_SIZE = 42,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [20:0] code_point, [37:21] query_index
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [16:0] trigram_index, [48:17] trigram_count
);

    localparam int DEPTH    = ALPHABET_SIZE * ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LETTER_W = $clog2(ALPHABET_SIZE);
    localparam int CP_W     = lth_pkg::CP_W;
    localparam int QIDX_W   = lth_pkg::QIDX_W;
    localparam int OCNT_W   = lth_pkg::OUT_CNT_W;

    // ---------------- control: clearing sweep, then run ----------------
    lth_pkg::t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic clr_we;
    logic clr_last;

    assign clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lth_pkg::ST_CLEAR: if (clr_last) n_state = lth_pkg::ST_RUN;
            lth_pkg::ST_RUN:   n_state = lth_pkg::ST_RUN;
            default:           n_state = lth_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        unique case (r_state)
            lth_pkg::ST_CLEAR: clr_we = 1'b1;
            lth_pkg::ST_RUN:   clr_we = 1'b0;
            default:           clr_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lth_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // ---------------- input transfer and credits ----------------
    logic [lth_pkg::OUT_LVL_W-1:0] r_credit;
    logic in_xfer, out_xfer;

    assign o_s_tready = (r_state == lth_pkg::ST_RUN)
                      && (r_credit < lth_pkg::OUT_LVL_W'(lth_pkg::OUT_DEPTH));
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_xfer   = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + lth_pkg::OUT_LVL_W'(in_xfer && i_s_tuser)
                                 - lth_pkg::OUT_LVL_W'(out_xfer);
        end
    end

    // ---------------- stage 1: input register ----------------
    logic              r1_valid;
    logic              r1_req;
    logic [CP_W-1:0]   r1_cp;
    logic [QIDX_W-1:0] r1_qidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else          r1_valid <= in_xfer;
    end

    always_ff @(posedge i_clk) begin
        r1_req  <= i_s_tuser;
        r1_cp   <= i_s_tdata[CP_W-1:0];
        r1_qidx <= i_s_tdata[CP_W+QIDX_W-1:CP_W];
    end

    // ---------------- letter decode and history ----------------
    lth_pkg::t_letter lk;
    logic              is_letter;
    logic              feed, query;
    logic [LETTER_W-1:0] r_older, r_newer, code;
    logic [1:0]        r_run;
    logic [ADDR_W-1:0] tri_addr;

    assign lk        = lth_pkg::letter_lookup(r1_cp);
    // codes at or above the alphabet size act as non-letters
    assign is_letter = lk.hit && ({1'b0, lk.code} < 7'(ALPHABET_SIZE));
    assign code      = LETTER_W'(lk.code);
    assign feed      = r1_valid && !r1_req;
    assign query     = r1_valid && r1_req;

    assign tri_addr = ADDR_W'(r_older) * ADDR_W'(ALPHABET_SIZE * ALPHABET_SIZE)
                    + ADDR_W'(r_newer) * ADDR_W'(ALPHABET_SIZE)
                    + ADDR_W'(code);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= '0;
            r_newer <= '0;
            r_run   <= '0;
        end else if (feed) begin
            if (is_letter) begin
                r_older <= r_newer;
                r_newer <= code;
                if (r_run != 2'd2) r_run <= r_run + 2'd1;
            end else begin
                r_run <= '0;
            end
        end
    end

    // ---------------- stage 2: RAM read ----------------
    lth_pkg::t_op      r2_op;
    logic [ADDR_W-1:0] r2_addr;
    logic [QIDX_W-1:0] r2_qidx;
    logic              r2_oob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_op <= lth_pkg::OP_NONE;
        end else if (query) begin
            r2_op <= lth_pkg::OP_QUERY;
        end else if (feed && is_letter && r_run == 2'd2) begin
            r2_op <= lth_pkg::OP_INCR;
        end else begin
            r2_op <= lth_pkg::OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_addr <= r1_req ? ADDR_W'(r1_qidx) : tri_addr;
        r2_qidx <= r1_qidx;
        r2_oob  <= (32'(r1_qidx) >= 32'(DEPTH));
    end

    // ---------------- stage 3: modify and write back ----------------
    lth_pkg::t_op           r3_op;
    logic [ADDR_W-1:0]      r3_addr;
    logic [QIDX_W-1:0]      r3_qidx;
    logic                   r3_oob;
    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_fwd_hit, n_fwd_hit;
    logic [COUNT_WIDTH-1:0] r_fwd_data;
    logic [COUNT_WIDTH-1:0] cur, inc;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_op     <= lth_pkg::OP_NONE;
            r_fwd_hit <= 1'b0;
        end else begin
            r3_op     <= r2_op;
            r_fwd_hit <= n_fwd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_addr    <= r2_addr;
        r3_qidx    <= r2_qidx;
        r3_oob     <= r2_oob;
        r_fwd_data <= inc;
    end

    // read of stage 2 races the write of stage 3 on the same counter
    assign n_fwd_hit = (r3_op == lth_pkg::OP_INCR) && (r2_op != lth_pkg::OP_NONE)
                     && (r2_addr == r3_addr);
    assign cur = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign inc = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);

    assign wr_en   = clr_we || (r3_op == lth_pkg::OP_INCR);
    assign wr_addr = clr_we ? r_clr_addr : r3_addr;
    assign wr_data = clr_we ? '0 : inc;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd_data <= r_mem[r2_addr];
    end

    // ---------------- result queue ----------------
    logic [QIDX_W-1:0]              r_q_idx [lth_pkg::OUT_DEPTH];
    logic [OCNT_W-1:0]              r_q_cnt [lth_pkg::OUT_DEPTH];
    logic [lth_pkg::OUT_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [lth_pkg::OUT_LVL_W-1:0]  r_level;
    logic                           push;

    assign push = (r3_op == lth_pkg::OP_QUERY);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_idx[r_wr_ptr] <= r3_qidx;
            r_q_cnt[r_wr_ptr] <= r3_oob ? '0 : OCNT_W'(cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push)     r_wr_ptr <= r_wr_ptr + lth_pkg::OUT_PTR_W'(1);
            if (out_xfer) r_rd_ptr <= r_rd_ptr + lth_pkg::OUT_PTR_W'(1);
            r_level <= r_level + lth_pkg::OUT_LVL_W'(push)
                               - lth_pkg::OUT_LVL_W'(out_xfer);
        end
    end

    assign o_m_tvalid = (r_level != '0);
    assign o_m_tdata  = {7'd0, r_q_cnt[r_rd_ptr], r_q_idx[r_rd_ptr]};

    // ---------------- assertions ----------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= lth_pkg::OUT_LVL_W'(lth_pkg::OUT_DEPTH))
        else $error("credit count above queue depth");

    a_level_vs_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= r_credit)
        else $error("queue holds more results than reserved");

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lth_pkg::ST_CLEAR) |-> !o_s_tready)
        else $error("input taken during clearing sweep");

    a_fwd_after_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> $past(r3_op == lth_pkg::OP_INCR))
        else $error("bypass used without a preceding write");

    a_pipe_empty_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lth_pkg::ST_CLEAR) |-> (r3_op == lth_pkg::OP_NONE))
        else $error("write-back during clearing sweep");

endmodule
